// File: design/pba_pkg.sv
package pba_pkg;

  localparam int MAP_WORDS_DEF = 2048;
  localparam int PAGES_PER_WORD = 32;
  localparam int REG_W = 12;
  localparam int PAGE_W = 16;
  localparam int COUNT_W = 17;
  localparam int STATUS_W = 2;
  localparam int OP_W = 3;
  localparam int CFG_INDEX_W = 1;
  localparam logic [31:0] ALL_SET = 32'hFFFF_FFFF;
  localparam logic [COUNT_W-1:0] COUNTER_MAX = 17'h1FFFF;

  localparam logic [OP_W-1:0] OP_ALLOC        = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC_LOW    = 3'd1;
  localparam logic [OP_W-1:0] OP_FREE         = 3'd2;
  localparam logic [OP_W-1:0] OP_REG_AVAIL    = 3'd3;
  localparam logic [OP_W-1:0] OP_REG_RESERVED = 3'd4;
  localparam logic [OP_W-1:0] OP_REG_REMOVED  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOM  = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_WORDS_IN_USE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOW_WORDS    = 1'd1;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_DECODE, S_SRCH_START, S_SRCH_READ, S_SRCH_TEST,
    S_CHK_READ, S_CHK_TEST, S_MARK_READ, S_MARK_WRITE, S_FILL_READ,
    S_FILL_WRITE, S_DONE
  } pba_state_t;

  // Mask of in-word positions [a, b); position 0 is the most significant bit.
  function automatic logic [31:0] span_mask(input logic [4:0] a, input logic [5:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = ALL_SET >> a;
    lo = (b >= 6'd32) ? 32'd0 : (ALL_SET >> b);
    return hi & ~lo;
  endfunction

  function automatic logic [4:0] first_zero(input logic [31:0] w);
    logic [4:0] p;
    p = 5'd31;
    for (int i = 31; i >= 0; i--) begin
      if (!w[31-i]) begin
        p = 5'(i);
      end
    end
    return p;
  endfunction

endpackage

// File: design/pba_if.sv
interface pba_in_if;
  logic                    valid;
  logic                    ready;
  logic [2:0]              opcode;
  logic [15:0]             page;
  logic [16:0]             count;
  modport source (output valid, opcode, page, count, input ready);
  modport sink (input valid, opcode, page, count, output ready);
endinterface

interface pba_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] first_page;
  logic [1:0]  status;
  logic [16:0] free_count;
  logic [16:0] total_count;
  modport source (output valid, first_page, status, free_count, total_count, input ready);
  modport sink (input valid, first_page, status, free_count, total_count, output ready);
endinterface

// File: design/page_bitmap_allocator.sv
// Bitmap page allocator. Each item is one transaction on the input channel
// (allocate, allocate_low, free, region_available, region_reserved,
// region_removed) and yields exactly one result transaction. The page map
// sits in a single-port-read memory worked by one sequencer, which touches
// one 32-page word at a time (read, then test or write). After reset
// a clearing pass sets all MAP_WORDS words to allocated, during which no
// item is accepted. A free or region operation reads and writes each word
// spanned; an allocation reads and tests each word scanned from the head,
// then checks and marks each word of the run. A result is held in an
// output register; the next item is taken only once it has gone.
module page_bitmap_allocator #(
  parameter int MAP_WORDS = pba_pkg::MAP_WORDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [11:0]           cfg_data,
  pba_in_if.sink                in_ch,
  pba_out_if.source             out_ch
);
  import pba_pkg::*;

  localparam int AW = $clog2(MAP_WORDS);
  localparam int WW = AW + 1;            // word numbers up to MAP_WORDS
  localparam int PW = WW + 5;            // page numbers up to the map end
  // Room for page + count, whichever of the map or the count field is wider.
  localparam int EW = ((PW > COUNT_W) ? PW : COUNT_W) + 1;
  localparam logic [WW-1:0] MAPW = WW'(MAP_WORDS);
  localparam logic [EW-1:0] LIMIT = EW'(MAP_WORDS) << 5;

  pba_state_t state, state_next;

  logic [REG_W-1:0] words_in_use, low_region_words;
  logic [WW-1:0]    main_head, low_head;
  logic [COUNT_W-1:0] free_pages, total_pages;

  // Latched item.
  logic [OP_W-1:0]    op;
  logic [PAGE_W-1:0]  page_in;
  logic [COUNT_W-1:0] cnt;

  // Sequencer working registers.
  logic [WW-1:0] lo, hi, cur, scanned, span;
  logic          in_low;                // searching the low region
  logic [EW-1:0] run_start, run_end;    // range for check, mark or fill
  logic [EW-1:0] cand;                  // candidate first page
  logic [WW-1:0] wptr, ew_last;
  logic          fill_set;
  logic [31:0]   rword;

  // Output register.
  logic                out_valid;
  logic [PAGE_W-1:0]   first_page_q;
  logic [STATUS_W-1:0] status_q;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata;

  pba_map_ram #(.MAP_WORDS(MAP_WORDS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(rword)
  );

  // Registers clipped to the map.
  logic [WW-1:0] used, low_w, main_lo;
  always_comb begin
    used    = (int'(words_in_use) > MAP_WORDS) ? MAPW : WW'(words_in_use);
    low_w   = (int'(low_region_words) > int'(used)) ? used : WW'(low_region_words);
    main_lo = low_w;
  end

  // Span mask of the word at wptr for range [run_start, run_end).
  logic [WW-1:0] sw;
  logic [4:0]    ma;
  logic [5:0]    mb;
  logic [31:0]   mask;
  logic [EW-1:0] last_page;
  always_comb begin
    last_page = run_end - EW'(1);
    sw   = WW'(run_start >> 5);
    ma   = (wptr == sw) ? run_start[4:0] : 5'd0;
    mb   = (wptr == ew_last) ? {1'b0, last_page[4:0]} + 6'd1 : 6'd32;
    mask = span_mask(ma, mb);
  end

  logic [4:0]    fz;
  logic [EW-1:0] cand_c;
  assign fz     = first_zero(rword);
  assign cand_c = (EW'(cur) << 5) + EW'(fz);

  // Free/region range clip.
  logic [EW-1:0] f_start, f_end_raw, f_end, f_len;
  always_comb begin
    f_start   = (EW'(page_in) > LIMIT) ? LIMIT : EW'(page_in);
    f_end_raw = EW'(page_in) + EW'(cnt);
    f_end     = (f_end_raw > LIMIT) ? LIMIT : f_end_raw;
    f_len     = (f_end > f_start) ? f_end - f_start : EW'(0);
  end

  function automatic logic [COUNT_W-1:0] sat_add(input logic [COUNT_W-1:0] x,
                                                 input logic [EW-1:0] n);
    logic [EW+1:0] s;
    s = (EW+2)'(x) + (EW+2)'(n);
    return (s > (EW+2)'(COUNTER_MAX)) ? COUNTER_MAX : COUNT_W'(s);
  endfunction

  function automatic logic [COUNT_W-1:0] sat_sub(input logic [COUNT_W-1:0] x,
                                                 input logic [EW-1:0] n);
    logic [EW+1:0] d;
    d = (EW+2)'(x) - (EW+2)'(n);
    return ((EW+2)'(x) > (EW+2)'(n)) ? COUNT_W'(d) : '0;
  endfunction

  logic range_hit;   // mark or check word spans past the map
  assign range_hit = (wptr >= MAPW);

  // Search decisions. A word holds a candidate when it is not full and the
  // run from its first free page ends inside the region. The head moves on
  // when there is no candidate or the pages after it are not all free.
  logic          hit, chk_fail, adv, turn_done;
  logic [WW-1:0] nxt;
  always_comb begin
    hit       = (rword != ALL_SET) && (cand_c + EW'(cnt) <= (EW'(hi) << 5));
    chk_fail  = range_hit || (rword & mask) != '0;
    adv       = ((state == S_SRCH_TEST) && !hit) || ((state == S_CHK_TEST) && chk_fail);
    turn_done = (scanned + WW'(1) >= span);
    nxt       = (cur + WW'(1) >= hi) ? lo : cur + WW'(1);
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:       if (in_ch.valid && !out_valid) state_next = S_DECODE;
      S_CLEAR:      if (wptr == WW'(MAP_WORDS - 1)) state_next = S_IDLE;
      S_DECODE: begin
        if (op <= OP_ALLOC_LOW) begin
          state_next = (cnt == '0) ? S_DONE : S_SRCH_START;
        end else if (op <= OP_REG_REMOVED && f_end > f_start) begin
          state_next = S_FILL_READ;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SRCH_START: begin
        if (hi <= lo) begin
          // An empty main region falls back to the low region.
          state_next = in_low ? S_DONE : S_SRCH_START;
        end else begin
          state_next = S_SRCH_READ;
        end
      end
      S_SRCH_READ:  state_next = S_SRCH_TEST;
      S_SRCH_TEST: begin
        if (hit) begin
          state_next = (cnt == COUNT_W'(1)) ? S_MARK_READ : S_CHK_READ;
        end else if (turn_done) begin
          state_next = in_low ? S_DONE : S_SRCH_START;
        end else begin
          state_next = S_SRCH_READ;
        end
      end
      S_CHK_READ:   state_next = S_CHK_TEST;
      S_CHK_TEST: begin
        if (chk_fail) begin
          if (turn_done) begin
            state_next = in_low ? S_DONE : S_SRCH_START;
          end else begin
            state_next = S_SRCH_READ;
          end
        end else if (wptr == ew_last) begin
          state_next = S_MARK_READ;
        end else begin
          state_next = S_CHK_READ;
        end
      end
      S_MARK_READ:  state_next = S_MARK_WRITE;
      S_MARK_WRITE: state_next = (wptr == ew_last) ? S_DONE : S_MARK_READ;
      S_FILL_READ:  state_next = S_FILL_WRITE;
      S_FILL_WRITE: state_next = (wptr == ew_last || wptr + WW'(1) >= MAPW)
                                 ? S_DONE : S_FILL_READ;
      S_DONE:       state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wptr[AW-1:0];
    ram_wdata = rword | mask;
    ram_raddr = wptr[AW-1:0];
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = ALL_SET;
      end
      S_SRCH_READ:  ram_raddr = cur[AW-1:0];
      S_MARK_WRITE: ram_we = 1'b1;
      S_FILL_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = fill_set ? (rword | mask) : (rword & ~mask);
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE) && !out_valid;

  // Datapath and sequencing registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      wptr             <= '0;
      words_in_use     <= 12'd2048;
      low_region_words <= 12'd128;
      main_head        <= WW'(128);
      low_head         <= '0;
      free_pages       <= '0;
      total_pages      <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_WORDS_IN_USE: words_in_use <= cfg_data;
          CFG_LOW_WORDS:    low_region_words <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ch.ready) out_valid <= 1'b0;

      unique case (state)
        S_CLEAR: wptr <= wptr + WW'(1);
        S_IDLE: begin
          if (in_ch.valid && !out_valid) begin
            op      <= in_ch.opcode;
            page_in <= in_ch.page;
            cnt     <= in_ch.count;
          end
        end
        S_DECODE: begin
          first_page_q <= '0;
          status_q     <= ST_OK;
          if (op <= OP_ALLOC_LOW) begin
            if (cnt == '0) begin
              status_q <= ST_ZERO;
            end else begin
              in_low <= (op == OP_ALLOC_LOW);
              lo     <= (op == OP_ALLOC_LOW) ? '0 : main_lo;
              hi     <= (op == OP_ALLOC_LOW) ? low_w : used;
            end
          end else if (op <= OP_REG_REMOVED) begin
            run_start <= f_start;
            run_end   <= f_end;
            wptr      <= WW'(f_start >> 5);
            ew_last   <= WW'((f_end - EW'(1)) >> 5);
            fill_set  <= (op >= OP_REG_RESERVED);
            unique case (op)
              OP_FREE: free_pages <= sat_add(free_pages, f_len);
              OP_REG_AVAIL: begin
                free_pages  <= sat_add(free_pages, f_len);
                total_pages <= sat_add(total_pages, f_len);
              end
              OP_REG_RESERVED: free_pages <= sat_sub(free_pages, f_len);
              default: begin
                free_pages  <= sat_sub(free_pages, f_len);
                total_pages <= sat_sub(total_pages, f_len);
              end
            endcase
          end
        end
        S_SRCH_START: begin
          if (hi <= lo) begin
            if (in_low) begin
              status_q <= ST_OOM;
            end else begin
              in_low <= 1'b1;
              lo     <= '0;
              hi     <= low_w;
            end
          end else begin
            span    <= hi - lo;
            scanned <= '0;
            if (in_low) begin
              if (low_head < lo || low_head >= hi) begin
                low_head <= lo;
                cur      <= lo;
              end else begin
                cur <= low_head;
              end
            end else begin
              if (main_head < lo || main_head >= hi) begin
                main_head <= lo;
                cur       <= lo;
              end else begin
                cur <= main_head;
              end
            end
          end
        end
        S_SRCH_TEST: begin
          if (hit) begin
            // Candidate found; a single page is marked at once, a longer run
            // first has the pages after the candidate checked.
            cand    <= cand_c;
            run_end <= cand_c + EW'(cnt);
            if (cnt == COUNT_W'(1)) begin
              run_start <= cand_c;
              wptr      <= cur;
              ew_last   <= cur;
            end else begin
              run_start <= cand_c + EW'(1);
              wptr      <= WW'((cand_c + EW'(1)) >> 5);
              ew_last   <= WW'((cand_c + EW'(cnt) - EW'(1)) >> 5);
            end
          end
        end
        S_CHK_TEST: begin
          if (!chk_fail) begin
            if (wptr == ew_last) begin
              run_start <= cand;
              wptr      <= WW'(cand >> 5);
            end else begin
              wptr <= wptr + WW'(1);
            end
          end
        end
        S_MARK_WRITE: begin
          if (wptr == ew_last) begin
            free_pages   <= sat_sub(free_pages, EW'(cnt));
            first_page_q <= cand[PAGE_W-1:0];
          end else begin
            wptr <= wptr + WW'(1);
          end
        end
        S_FILL_WRITE: wptr <= wptr + WW'(1);
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase

      // Move the active head on one word; after a full turn fall back to the
      // low region, or report out of memory when that was the low region.
      if (adv) begin
        cur     <= nxt;
        scanned <= scanned + WW'(1);
        if (in_low) begin
          low_head <= nxt;
        end else begin
          main_head <= nxt;
        end
        if (turn_done) begin
          if (in_low) begin
            status_q <= ST_OOM;
          end else begin
            in_low <= 1'b1;
            lo     <= '0;
            hi     <= low_w;
          end
        end
      end
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.first_page  = first_page_q;
  assign out_ch.status      = status_q;
  assign out_ch.free_count  = free_pages;
  assign out_ch.total_count = total_pages;
endmodule

// File: design/pba_map_ram.sv
module pba_map_ram #(
  parameter int MAP_WORDS = pba_pkg::MAP_WORDS_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(MAP_WORDS)-1:0] waddr,
  input  logic [31:0]                  wdata,
  input  logic [$clog2(MAP_WORDS)-1:0] raddr,
  output logic [31:0]                  rdata
);
  logic [31:0] mem [MAP_WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: dv/page_bitmap_allocator_tb.sv
`timescale 1ns / 1ps

module page_bitmap_allocator_tb;
  import pba_pkg::*;

  // The two spare opcodes the block must treat as no-operations.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;
  localparam int MAP_W = MAP_WORDS_DEF;
  localparam int MAP_PAGES = MAP_W * PAGES_PER_WORD;
  localparam int CNT_SAT = 'h1FFFF;
  // Cycles without any transaction before the run is declared hung. The
  // clearing pass, a full-map scan and the long output hold-off all fit
  // well inside this.
  localparam int HANG_LIMIT = 200000;

  typedef struct packed {
    logic [PAGE_W-1:0]   first_page;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
    logic [COUNT_W-1:0]  total_count;
  } alloc_result_t;

  typedef struct {
    logic [OP_W-1:0]    op;
    int                 page;
    int                 cnt;
    bit                 typed;
    alloc_result_t      res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [11:0] cfg_data = '0;

  pba_in_if in_ch();
  pba_out_if out_ch();

  page_bitmap_allocator i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the allocator state, kept in step with every accepted
  // transaction on the input channel.
  logic [31:0] shadow_map [MAP_W];
  int shadow_main_head;
  int shadow_low_head;
  int shadow_free;
  int shadow_total;
  int shadow_words;
  int shadow_low_words;

  alloc_result_t pending_results[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit calm = 1'b0;          // when set, neither side inserts random gaps
  bit hold_off_now = 1'b0;  // asks the result side for one long stall
  int hold_left = 0;

  function automatic logic [31:0] page_bits(int a, int b);
    logic [31:0] hi;
    logic [31:0] lo;
    hi = ALL_SET >> a;
    lo = (b >= 32) ? 32'd0 : (ALL_SET >> b);
    return hi & ~lo;
  endfunction

  // Sets or clears pages [s, e); words past the map end are ignored.
  function automatic void mark_pages(int s, int e, bit set);
    int sw;
    int ew;
    int a;
    int b;
    if (s >= e) return;
    sw = s >> 5;
    ew = (e - 1) >> 5;
    for (int w = sw; w <= ew && w < MAP_W; w++) begin
      a = (w == sw) ? (s & 31) : 0;
      b = (w == ew) ? (((e - 1) & 31) + 1) : 32;
      if (set) shadow_map[w] |= page_bits(a, b);
      else shadow_map[w] &= ~page_bits(a, b);
    end
  endfunction

  function automatic bit pages_clear(int s, int e);
    int sw;
    int ew;
    int a;
    int b;
    if (s >= e) return 1'b1;
    sw = s >> 5;
    ew = (e - 1) >> 5;
    for (int w = sw; w <= ew; w++) begin
      a = (w == sw) ? (s & 31) : 0;
      b = (w == ew) ? (((e - 1) & 31) + 1) : 32;
      if (w >= MAP_W) return 1'b0;
      if ((shadow_map[w] & page_bits(a, b)) != 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Scans words [lo, hi) from the head for the first free page whose run of
  // n pages is free and lies inside the region. The head stays on a hit.
  function automatic bit claim_run(int lo, int hi, inout int head, input int n,
                                   output int found);
    int w;
    int pos;
    int p;
    found = 0;
    if (hi <= lo) return 1'b0;
    if (head < lo || head >= hi) head = lo;
    for (int i = 0; i < hi - lo; i++) begin
      w = head;
      if (shadow_map[w] != ALL_SET) begin
        pos = 0;
        while (pos < 31 && shadow_map[w][31 - pos]) pos++;
        p = w * PAGES_PER_WORD + pos;
        if (p + n <= hi * PAGES_PER_WORD && pages_clear(p + 1, p + n)) begin
          mark_pages(p, p + n, 1'b1);
          shadow_free = (shadow_free > n) ? shadow_free - n : 0;
          found = p;
          return 1'b1;
        end
      end
      head = (w + 1 >= hi) ? lo : w + 1;
    end
    return 1'b0;
  endfunction

  function automatic alloc_result_t apply_request(logic [OP_W-1:0] op, int page, int cnt);
    alloc_result_t r;
    int used;
    int low;
    int first;
    int s;
    int e;
    int len;
    bit ok;
    r = '0;
    first = 0;
    used = (shadow_words > MAP_W) ? MAP_W : shadow_words;
    low = (shadow_low_words > used) ? used : shadow_low_words;
    case (op)
      OP_ALLOC, OP_ALLOC_LOW: begin
        if (cnt == 0) begin
          r.status = ST_ZERO;
        end else begin
          ok = 1'b0;
          if (op == OP_ALLOC) ok = claim_run(low, used, shadow_main_head, cnt, first);
          if (!ok) ok = claim_run(0, low, shadow_low_head, cnt, first);
          if (ok) r.first_page = first[PAGE_W-1:0];
          else r.status = ST_OOM;
        end
      end
      OP_FREE, OP_REG_AVAIL, OP_REG_RESERVED, OP_REG_REMOVED: begin
        s = (page > MAP_PAGES) ? MAP_PAGES : page;
        e = (page + cnt > MAP_PAGES) ? MAP_PAGES : page + cnt;
        len = (e > s) ? e - s : 0;
        if (op == OP_FREE || op == OP_REG_AVAIL) begin
          mark_pages(s, e, 1'b0);
          shadow_free = (shadow_free + len > CNT_SAT) ? CNT_SAT : shadow_free + len;
          if (op == OP_REG_AVAIL)
            shadow_total = (shadow_total + len > CNT_SAT) ? CNT_SAT : shadow_total + len;
        end else begin
          mark_pages(s, e, 1'b1);
          shadow_free = (shadow_free > len) ? shadow_free - len : 0;
          if (op == OP_REG_REMOVED)
            shadow_total = (shadow_total > len) ? shadow_total - len : 0;
        end
      end
      default: ;
    endcase
    r.free_count = shadow_free[COUNT_W-1:0];
    r.total_count = shadow_total[COUNT_W-1:0];
    return r;
  endfunction

  // Offers one request, keeping valid high from the previous request unless
  // a random gap comes first. The shadow state moves on acceptance.
  task automatic send_request(logic [OP_W-1:0] op, int page, int cnt, bit typed = 1'b0,
                              alloc_result_t typed_res = '0);
    alloc_result_t r;
    while (!calm && $urandom_range(99) < 19) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.page <= page[PAGE_W-1:0];
    in_ch.count <= cnt[COUNT_W-1:0];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = apply_request(op, page, cnt);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Register writes happen only once every result is back and the block
  // has had time to settle.
  task automatic program_regs(int words, int low_words);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_WORDS_IN_USE;
    cfg_data <= words[11:0];
    @(posedge clk);
    cfg_index <= CFG_LOW_WORDS;
    cfg_data <= low_words[11:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_words = words & 'hFFF;
    shadow_low_words = low_words & 'hFFF;
  endtask

  // One phase: wipe the map, make a small area usable, then a random mix
  // that is mostly allocations and frees inside that area.
  task automatic run_phase(int words, int low_words, int n_items, bit quiet, bit squeeze);
    int used;
    int area;
    int sel;
    int pg;
    int ct;
    program_regs(words, low_words);
    calm = quiet;
    used = (words & 'hFFF) > MAP_W ? MAP_W : (words & 'hFFF);
    area = ((used > 64) ? 64 : ((used < 1) ? 1 : used)) * PAGES_PER_WORD;
    send_request(OP_REG_REMOVED, 0, MAP_PAGES);
    send_request(OP_REG_AVAIL, 0, area);
    for (int i = 0; i < n_items; i++) begin
      if (squeeze && i == n_items / 2) hold_off_now = 1'b1;
      sel = $urandom_range(99);
      pg = $urandom_range(area - 1);
      ct = $urandom_range(48);
      if (sel < 35) begin
        send_request(OP_ALLOC, 0, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 40));
      end else if (sel < 45) begin
        send_request(OP_ALLOC_LOW, 0, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12));
      end else if (sel < 65) begin
        send_request(OP_FREE, pg, ct);
      end else if (sel < 75) begin
        send_request(OP_REG_RESERVED, pg, ct);
      end else if (sel < 85) begin
        send_request(OP_REG_AVAIL, pg, ct);
      end else if (sel < 90) begin
        send_request(OP_REG_REMOVED, pg, ct);
      end else if (sel < 98) begin
        // Noise: any opcode and any page, small count.
        send_request($urandom_range(7), $urandom_range(65535), $urandom_range(70));
      end else begin
        // Rare wide request; the count field may carry its top bit.
        send_request($urandom_range(7), $urandom_range(65535), $urandom_range(131071));
      end
    end
    calm = 1'b0;
  endtask

  dir_row_t dir_rows[] = '{
    '{OP_ALLOC,        0,     0,      1'b1, '{16'd0, ST_ZERO, 17'd0, 17'd0}},
    '{OP_ALLOC,        0,     1,      1'b1, '{16'd0, ST_OOM, 17'd0, 17'd0}},
    '{OP_ALLOC_LOW,    0,     0,      1'b1, '{16'd0, ST_ZERO, 17'd0, 17'd0}},
    '{OP_SPARE_A,      5,     5,      1'b1, '{16'd0, ST_OK, 17'd0, 17'd0}},
    '{OP_REG_AVAIL,    0,     64,     1'b1, '{16'd0, ST_OK, 17'd64, 17'd64}},
    '{OP_ALLOC,        0,     1,      1'b1, '{16'd0, ST_OK, 17'd63, 17'd64}},
    '{OP_ALLOC_LOW,    0,     3,      1'b0, '0},
    '{OP_FREE,         0,     4,      1'b0, '0},
    '{OP_REG_RESERVED, 10,    5,      1'b0, '0},
    '{OP_REG_REMOVED,  60,    10,     1'b0, '0},
    '{OP_REG_AVAIL,    4096,  64,     1'b0, '0},
    '{OP_ALLOC,        0,     33,     1'b0, '0},
    '{OP_ALLOC,        0,     65536,  1'b0, '0},
    '{OP_REG_AVAIL,    65535, 65536,  1'b0, '0},
    '{OP_FREE,         65535, 131071, 1'b0, '0},
    '{OP_SPARE_B,      65535, 131071, 1'b0, '0},
    '{OP_REG_AVAIL,    0,     0,      1'b0, '0},
    '{OP_REG_RESERVED, 0,     65536,  1'b0, '0},
    '{OP_REG_REMOVED,  0,     65536,  1'b0, '0},
    '{OP_REG_AVAIL,    0,     65536,  1'b0, '0},
    '{OP_REG_AVAIL,    0,     65536,  1'b0, '0},
    '{OP_ALLOC,        0,     65536,  1'b0, '0},
    '{OP_ALLOC_LOW,    0,     4096,   1'b0, '0},
    '{OP_REG_REMOVED,  0,     65536,  1'b0, '0}
  };

  // Result side: random back-pressure, plus one long hold-off on request so
  // that the output register fills and the input channel stalls.
  always @(posedge clk) begin
    if (hold_off_now) begin
      hold_off_now = 1'b0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 19);
    end
  end

  // Compares every result transaction with the oldest expectation.
  always @(posedge clk) begin
    alloc_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result first=%0d status=%0d free=%0d total=%0d", $time,
                 out_ch.first_page, out_ch.status, out_ch.free_count, out_ch.total_count);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.first_page !== want.first_page) begin
          $display("%0t: first_page expected %0d got %0d", $time, want.first_page,
                   out_ch.first_page);
          errors++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, out_ch.status);
          errors++;
        end
        if (out_ch.free_count !== want.free_count) begin
          $display("%0t: free_count expected %0d got %0d", $time, want.free_count,
                   out_ch.free_count);
          errors++;
        end
        if (out_ch.total_count !== want.total_count) begin
          $display("%0t: total_count expected %0d got %0d", $time, want.total_count,
                   out_ch.total_count);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles in which neither channel moves a transaction.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("[page_bitmap_allocator] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_ALLOC;
    in_ch.page = '0;
    in_ch.count = '0;
    out_ch.ready = 1'b0;
    foreach (shadow_map[w]) shadow_map[w] = ALL_SET;
    shadow_words = MAP_W;
    shadow_low_words = 128;
    shadow_main_head = 128;
    shadow_low_head = 0;
    shadow_free = 0;
    shadow_total = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed table, run with the reset register values.
    foreach (dir_rows[k])
      send_request(dir_rows[k].op, dir_rows[k].page, dir_rows[k].cnt, dir_rows[k].typed,
                   dir_rows[k].res);

    // Register settings, extremes among them: an empty low region, a low
    // region covering everything, values past the map, and no memory.
    run_phase(8, 2, 250, 1'b0, 1'b1);
    run_phase(1, 0, 100, 1'b0, 1'b0);
    run_phase(16, 16, 150, 1'b0, 1'b0);
    run_phase(32, 4, 300, 1'b1, 1'b0);
    run_phase(4095, 4095, 30, 1'b0, 1'b0);
    run_phase(0, 5, 40, 1'b0, 1'b0);
    run_phase(2048, 2047, 40, 1'b0, 1'b0);
    run_phase(3, 1, 300, 1'b0, 1'b0);
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[page_bitmap_allocator] OK");
    end else begin
      $display("[page_bitmap_allocator] ERROR");
    end
    $finish;
  end

endmodule

// File: page_bitmap_allocator.f
design/pba_pkg.sv
design/pba_if.sv
design/pba_map_ram.sv
design/page_bitmap_allocator.sv
dv/page_bitmap_allocator_tb.sv
